// File: hw/rtl/kbhcd_pkg.sv
// Shared constants, types and keycode helpers for the hotkey chord detector.
package kbhcd_pkg;

    // Number of key fields carried by one keyboard report.
    localparam int NUM_KEY_FIELDS = 6;

    // Modifier byte layout.
    localparam int         RCTRL_BIT  = 4;
    localparam logic [7:0] RCTRL_MASK = 8'h10;

    // HID keycodes of interest.
    localparam logic [7:0] KC_NONE    = 8'h00;
    localparam logic [7:0] KC_ESC     = 8'h29;
    localparam logic [7:0] KC_1       = 8'h1E;
    localparam logic [7:0] KC_9       = 8'h26;
    localparam logic [7:0] KC_0       = 8'h27;
    localparam logic [7:0] KC_KP_1    = 8'h59;
    localparam logic [7:0] KC_KP_9    = 8'h61;
    localparam logic [7:0] KC_KP_0    = 8'h62;

    // Millisecond to microsecond scale.
    localparam logic [9:0] US_PER_MS  = 10'd1000;

    // Detector modes.
    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_ARMED = 2'd1;
    localparam logic [1:0] MODE_CMD   = 2'd2;

    // Event codes.
    localparam logic [1:0] EV_NONE     = 2'd0;
    localparam logic [1:0] EV_CMD_ON   = 2'd1;
    localparam logic [1:0] EV_SWITCHED = 2'd2;
    localparam logic [1:0] EV_INVALID  = 2'd3;

    // Item actions.
    localparam logic ACT_REPORT = 1'b0;
    localparam logic ACT_POLL   = 1'b1;

    // Configuration register indexes.
    localparam logic [7:0] CFG_TAP_WINDOW  = 8'd0;
    localparam logic [7:0] CFG_CMD_TIMEOUT = 8'd1;
    localparam logic [7:0] CFG_SLOT_MASK   = 8'd2;

    // Reset values of the scaled windows (300 ms and 3000 ms).
    localparam logic [23:0] TAP_WINDOW_US_RST  = 24'd300000;
    localparam logic [25:0] CMD_TIMEOUT_US_RST = 26'd3000000;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic [23:0] tap_window_us;
        logic [25:0] cmd_timeout_us;
        logic [9:0]  slot_mask;
    } cfg_t;

    // One input item.
    typedef struct packed {
        logic                           action;
        logic [47:0]                    now_us;
        logic [7:0]                     modifiers;
        logic [NUM_KEY_FIELDS-1:0][7:0] keys;
    } item_t;

    // One result item.
    typedef struct packed {
        logic       forward_report;
        logic       send_empty_report;
        logic       do_switch;
        logic [1:0] event_code;
        logic [3:0] event_slot;
        logic       command_off;
        logic [1:0] mode_now;
    } res_t;

    // Decoded digit key.
    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } digit_t;

    // Outcome of the fresh-key scan of one report.
    typedef struct packed {
        logic       any_key;
        logic       hit;
        logic       is_esc;
        logic [3:0] digit;
    } scan_t;

    // Slot digit of a top-row or keypad digit key.
    function automatic digit_t digit_of(input logic [7:0] k);
        digit_t d;
        d = '0;
        if (k inside {[KC_1:KC_9]}) begin
            d.valid = 1'b1;
            d.value = 4'(k - KC_1) + 4'd1;
        end else if (k inside {[KC_KP_1:KC_KP_9]}) begin
            d.valid = 1'b1;
            d.value = 4'(k - KC_KP_1) + 4'd1;
        end else if (k inside {KC_0, KC_KP_0}) begin
            d.valid = 1'b1;
            d.value = 4'd0;
        end
        return d;
    endfunction

endpackage

// File: hw/rtl/kbhcd_cfg.sv
// Configuration registers; the windows are kept pre-scaled to microseconds.
module kbhcd_cfg
    import kbhcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output cfg_t        cfg
);

    logic [23:0] tap_window_us_reg;
    logic [25:0] cmd_timeout_us_reg;
    logic [9:0]  slot_mask_reg;
    logic        wr_en;

    // Writes are always taken.
    assign cfg_ready = 1'b1;
    assign wr_en     = cfg_valid && cfg_ready;

    // Scale milliseconds on the way in so the datapath only adds.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_window_us_reg  <= TAP_WINDOW_US_RST;
            cmd_timeout_us_reg <= CMD_TIMEOUT_US_RST;
            slot_mask_reg      <= '0;
        end
        else if (wr_en)
        begin
            case (cfg_index)
                CFG_TAP_WINDOW:
                    tap_window_us_reg <= 24'({10'd0, cfg_data[13:0]} * {14'd0, US_PER_MS});
                CFG_CMD_TIMEOUT:
                    cmd_timeout_us_reg <= 26'({10'd0, cfg_data} * {16'd0, US_PER_MS});
                CFG_SLOT_MASK:
                    slot_mask_reg <= cfg_data[9:0];
                default:
                    ;
            endcase
        end
    end

    assign cfg.tap_window_us  = tap_window_us_reg;
    assign cfg.cmd_timeout_us = cmd_timeout_us_reg;
    assign cfg.slot_mask      = slot_mask_reg;

endmodule

// File: hw/rtl/kbhcd_keyscan.sv
// Fresh-key scan: finds the first newly pressed Esc or digit of a report.
module kbhcd_keyscan
    import kbhcd_pkg::*;
#(
    parameter int KEYS_PER_REPORT = 6
)
(
    input  logic [NUM_KEY_FIELDS-1:0][7:0]  keys,
    input  logic [KEYS_PER_REPORT-1:0][7:0] last_keys,
    output scan_t                           scan
);

    logic [KEYS_PER_REPORT-1:0] fresh;
    digit_t                     digs [KEYS_PER_REPORT];

    // Per-position digit decode.
    always_comb
    begin
        for (int i = 0; i < KEYS_PER_REPORT; i++)
        begin
            digs[i] = digit_of(keys[i]);
        end
    end

    // A key is fresh when it is present and was not held in the last report.
    always_comb
    begin
        for (int i = 0; i < KEYS_PER_REPORT; i++)
        begin
            fresh[i] = (keys[i] != KC_NONE);
            for (int j = 0; j < KEYS_PER_REPORT; j++)
            begin
                if (keys[i] == last_keys[j])
                begin
                    fresh[i] = 1'b0;
                end
            end
        end
    end

    // Walk from the last position down so the first position wins.
    always_comb
    begin
        scan = '0;
        for (int i = KEYS_PER_REPORT - 1; i >= 0; i--)
        begin
            if (keys[i] != KC_NONE)
            begin
                scan.any_key = 1'b1;
            end
            if (fresh[i] && (keys[i] == KC_ESC || digs[i].valid))
            begin
                scan.hit    = 1'b1;
                scan.is_esc = (keys[i] == KC_ESC);
                scan.digit  = (keys[i] == KC_ESC) ? 4'd0 : digs[i].value;
            end
        end
    end

endmodule

// File: hw/rtl/kbhcd_core.sv
// Detector state and the one-pass update that turns a staged item into a result.
module kbhcd_core
    import kbhcd_pkg::*;
#(
    parameter int KEYS_PER_REPORT = 6
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  advance,
    input  item_t item,
    input  cfg_t  cfg,
    output res_t  result
);

    logic [1:0]                     mode_reg, mode_next;
    logic                           last_rctrl_reg, last_rctrl_next;
    logic                           tap_reg, tap_next;
    logic [47:0]                    tap_begin_reg, tap_begin_next;
    logic [48:0]                    armed_dl_reg, armed_dl_next;
    logic [48:0]                    cmd_dl_reg, cmd_dl_next;
    logic [KEYS_PER_REPORT-1:0][7:0] last_keys_reg, last_keys_next;

    scan_t       scan;
    logic        rctrl;
    logic        other;
    logic        lone_press;
    logic [48:0] now49;
    logic        cmd_expired;
    logic        armed_expired;
    logic [47:0] tap_age;
    logic        tap_inside;
    logic [48:0] cmd_dl_new;
    logic [48:0] armed_dl_new;

    kbhcd_keyscan #(
        .KEYS_PER_REPORT(KEYS_PER_REPORT)
    ) u_keyscan (
        .keys      (item.keys),
        .last_keys (last_keys_reg),
        .scan      (scan)
    );

    // Report classification and time compares.
    assign rctrl         = item.modifiers[RCTRL_BIT];
    assign other         = ((item.modifiers & ~RCTRL_MASK) != 8'h00) || scan.any_key;
    assign lone_press    = rctrl && !other && !last_rctrl_reg;
    assign now49         = {1'b0, item.now_us};
    assign cmd_expired   = now49 > cmd_dl_reg;
    assign armed_expired = now49 > armed_dl_reg;
    assign tap_age       = item.now_us - tap_begin_reg;
    assign tap_inside    = (item.now_us < tap_begin_reg) ||
                           (tap_age < {24'd0, cfg.tap_window_us});
    assign cmd_dl_new    = now49 + {23'd0, cfg.cmd_timeout_us};
    assign armed_dl_new  = now49 + {25'd0, cfg.tap_window_us};

    // Mode update and result for one item.
    always_comb
    begin
        logic idle_path;
        logic swallow;
        logic leave;

        idle_path       = 1'b1;
        swallow         = 1'b0;
        leave           = 1'b0;
        mode_next       = mode_reg;
        last_rctrl_next = last_rctrl_reg;
        tap_next        = tap_reg;
        tap_begin_next  = tap_begin_reg;
        armed_dl_next   = armed_dl_reg;
        cmd_dl_next     = cmd_dl_reg;
        last_keys_next  = last_keys_reg;
        result          = '0;

        if (item.action == ACT_POLL)
        begin
            // Polls only apply the time-outs.
            if (mode_reg == MODE_CMD && cmd_expired)
            begin
                leave = 1'b1;
            end
            else if (mode_reg == MODE_ARMED && armed_expired)
            begin
                mode_next = MODE_IDLE;
            end
            swallow = 1'b1;
        end
        else
        begin
            if (mode_reg == MODE_CMD)
            begin
                // Command mode swallows; the first fresh Esc or digit decides.
                swallow = 1'b1;
                if (scan.hit)
                begin
                    leave = 1'b1;
                    if (!scan.is_esc)
                    begin
                        result.event_slot = scan.digit;
                        if (cfg.slot_mask[scan.digit])
                        begin
                            result.do_switch  = 1'b1;
                            result.event_code = EV_SWITCHED;
                        end
                        else
                        begin
                            result.event_code = EV_INVALID;
                        end
                    end
                end
                else if (cmd_expired)
                begin
                    leave = 1'b1;
                end
            end
            else
            begin
                // Armed: a second lone press enters command mode.
                if (mode_reg == MODE_ARMED)
                begin
                    if (armed_expired)
                    begin
                        mode_next = MODE_IDLE;
                    end
                    else if (lone_press)
                    begin
                        mode_next         = MODE_CMD;
                        cmd_dl_next       = cmd_dl_new;
                        result.event_code = EV_CMD_ON;
                        swallow           = 1'b1;
                        idle_path         = 1'b0;
                    end
                    else if (other)
                    begin
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        idle_path = 1'b0;
                    end
                end

                // Lone tap tracking.
                if (idle_path)
                begin
                    if (lone_press)
                    begin
                        tap_next       = 1'b1;
                        tap_begin_next = item.now_us;
                    end
                    else if (tap_reg && !rctrl)
                    begin
                        if (!other && tap_inside)
                        begin
                            mode_next     = MODE_ARMED;
                            armed_dl_next = armed_dl_new;
                        end
                        tap_next = 1'b0;
                    end
                    else if (other)
                    begin
                        tap_next = 1'b0;
                    end
                end
            end

            last_rctrl_next = rctrl;
            last_keys_next  = item.keys[KEYS_PER_REPORT-1:0];
        end

        // Every exit from command mode resyncs the target.
        if (leave)
        begin
            mode_next                = MODE_IDLE;
            tap_next                 = 1'b0;
            result.send_empty_report = 1'b1;
            result.command_off       = 1'b1;
        end

        result.forward_report = !swallow;
        result.mode_now       = mode_next;
    end

    // State registers move only when the result is taken into the output stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            last_rctrl_reg <= 1'b0;
            tap_reg        <= 1'b0;
            tap_begin_reg  <= '0;
            armed_dl_reg   <= '0;
            cmd_dl_reg     <= '0;
            last_keys_reg  <= '0;
        end
        else if (advance)
        begin
            mode_reg       <= mode_next;
            last_rctrl_reg <= last_rctrl_next;
            tap_reg        <= tap_next;
            tap_begin_reg  <= tap_begin_next;
            armed_dl_reg   <= armed_dl_next;
            cmd_dl_reg     <= cmd_dl_next;
            last_keys_reg  <= last_keys_next;
        end
    end

endmodule

// File: hw/rtl/keyboard_hotkey_chord_detector.sv
// Top level of the Right Ctrl double-tap hotkey chord detector.
//
//   Channel | Handshake          | Beat contents
//   --------+--------------------+-----------------------------------------------
//   input   | in_valid/in_stall  | action, now_us, modifiers, key0..key5
//   output  | out_valid/out_stall| forward_report .. mode_now, one per input beat
//   config  | cfg_valid/cfg_ready| cfg_index (0..2), cfg_data
//
// One beat is taken per cycle while in_stall is low. A beat waits in the input register,
// then its result lands in the output register.
// The detector state updates as a result moves into the output register.
// Reset clears the state and loads the default windows; no clearing pass.
// A stalled output holds its beat; the input register still fills behind it.
module keyboard_hotkey_chord_detector
    import kbhcd_pkg::*;
#(
    parameter int KEYS_PER_REPORT = 6
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [47:0] now_us,
    input  logic [7:0]  modifiers,
    input  logic [7:0]  key0,
    input  logic [7:0]  key1,
    input  logic [7:0]  key2,
    input  logic [7:0]  key3,
    input  logic [7:0]  key4,
    input  logic [7:0]  key5,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        forward_report,
    output logic        send_empty_report,
    output logic        do_switch,
    output logic [1:0]  event_code,
    output logic [3:0]  event_slot,
    output logic        command_off,
    output logic [1:0]  mode_now,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t  cfg;
    item_t item_in;
    item_t item_reg;
    logic  stage_valid_reg;
    res_t  result;
    res_t  result_reg;
    logic  out_valid_reg;
    logic  advance;
    logic  accept;

    kbhcd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Gather the input beat.
    assign item_in.action    = action;
    assign item_in.now_us    = now_us;
    assign item_in.modifiers = modifiers;
    assign item_in.keys      = {key5, key4, key3, key2, key1, key0};

    // Staged item moves on when the output register is free or being drained.
    assign advance  = stage_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = stage_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_in;
        end
    end

    kbhcd_core #(
        .KEYS_PER_REPORT(KEYS_PER_REPORT)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result;
        end
    end

    assign out_valid         = out_valid_reg;
    assign forward_report    = result_reg.forward_report;
    assign send_empty_report = result_reg.send_empty_report;
    assign do_switch         = result_reg.do_switch;
    assign event_code        = result_reg.event_code;
    assign event_slot        = result_reg.event_slot;
    assign command_off       = result_reg.command_off;
    assign mode_now          = result_reg.mode_now;

    // A switch is signalled exactly with the switched event.
    a_switch_event: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (do_switch == (event_code == EV_SWITCHED)))
        else $error("do_switch and event_code disagree");

    // Leaving command mode always lands in idle with both exit flags.
    a_exit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && send_empty_report |-> command_off && (mode_now == MODE_IDLE))
        else $error("command exit without idle mode or notification");

    // Entering command mode swallows the report.
    a_cmd_on: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_code == EV_CMD_ON) |-> (mode_now == MODE_CMD) && !forward_report)
        else $error("command on without command mode");

    // The input side only stalls behind a held result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while output is free");

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the Right Ctrl double-tap hotkey chord detector.
`timescale 1ns / 1ps

module tb_top;
    import kbhcd_pkg::*;

    localparam int          NUM_SETTINGS      = 6;
    localparam int          BEATS_PER_SETTING = 185;
    localparam int          HOLD_AT_RESULT    = 400;
    localparam int          HOLD_CYCLES       = 300;
    localparam int unsigned CYCLE_LIMIT       = 200000;
    localparam logic [47:0] MAX_US            = 48'hFFFF_FFFF_FFFF;

    // Clock, reset and all block inputs start at known values.
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        action    = ACT_REPORT;
    logic [47:0] now_us    = '0;
    logic [7:0]  modifiers = '0;
    logic [7:0]  key0      = '0;
    logic [7:0]  key1      = '0;
    logic [7:0]  key2      = '0;
    logic [7:0]  key3      = '0;
    logic [7:0]  key4      = '0;
    logic [7:0]  key5      = '0;
    logic        out_stall = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [7:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    logic        in_stall;
    logic        out_valid;
    logic        forward_report;
    logic        send_empty_report;
    logic        do_switch;
    logic [1:0]  event_code;
    logic [3:0]  event_slot;
    logic        command_off;
    logic [1:0]  mode_now;
    logic        cfg_ready;

    // One directed beat, with an outcome typed in where it is obvious.
    typedef struct {
        item_t beat;
        bit    pinned;
        res_t  want;
    } probe_t;

    // Shadow configuration, masked to the register widths.
    logic [13:0] tap_ms_q;
    logic [15:0] cmd_ms_q;
    logic [9:0]  slot_mask_q;

    // Shadow detector state.
    logic [1:0]  det_mode;
    bit          rctrl_prev;
    bit          tap_open;
    logic [47:0] tap_origin_us;
    logic [48:0] arm_deadline_us;
    logic [48:0] cmd_deadline_us;
    logic [7:0]  keys_prev [NUM_KEY_FIELDS];

    res_t        pending_outcomes [$];
    item_t       key_beats [$];
    probe_t      probes [$];
    logic [47:0] clock_us;

    bit tx_burst = 1'b0;
    bit rx_burst = 1'b0;
    int mismatches   = 0;
    int results_seen = 0;
    int beats_sent   = 0;
    int n_cmd_on     = 0;
    int n_switched   = 0;
    int n_invalid    = 0;
    int n_other_exit = 0;

    keyboard_hotkey_chord_detector uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .action            (action),
        .now_us            (now_us),
        .modifiers         (modifiers),
        .key0              (key0),
        .key1              (key1),
        .key2              (key2),
        .key3              (key3),
        .key4              (key4),
        .key5              (key5),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .forward_report    (forward_report),
        .send_empty_report (send_empty_report),
        .do_switch         (do_switch),
        .event_code        (event_code),
        .event_slot        (event_slot),
        .command_off       (command_off),
        .mode_now          (mode_now),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always #10 clk = ~clk;

    // Returns the shadow detector to its power-on state and default windows.
    function automatic void reset_shadow();
        int i;
        tap_ms_q        = 14'd300;
        cmd_ms_q        = 16'd3000;
        slot_mask_q     = '0;
        det_mode        = MODE_IDLE;
        rctrl_prev      = 1'b0;
        tap_open        = 1'b0;
        tap_origin_us   = '0;
        arm_deadline_us = '0;
        cmd_deadline_us = '0;
        for (i = 0; i < NUM_KEY_FIELDS; i++)
            keys_prev[i] = KC_NONE;
    endfunction

    // Slot number of a top-row or keypad digit, or -1 for any other key.
    function automatic int slot_of_key(logic [7:0] k);
        if (k >= KC_1 && k <= KC_9)
            return int'(k - KC_1) + 1;
        if (k >= KC_KP_1 && k <= KC_KP_9)
            return int'(k - KC_KP_1) + 1;
        if (k == KC_0 || k == KC_KP_0)
            return 0;
        return -1;
    endfunction

    // A key counts as held when the previous report already carried it.
    function automatic bit held_last_report(logic [7:0] k);
        int i;
        for (i = 0; i < NUM_KEY_FIELDS; i++)
            if (keys_prev[i] == k)
                return 1'b1;
        return 1'b0;
    endfunction

    // Any exit from command mode resyncs the target and notifies.
    function automatic res_t leave_cmd(res_t r);
        det_mode            = MODE_IDLE;
        tap_open            = 1'b0;
        r.send_empty_report = 1'b1;
        r.command_off       = 1'b1;
        return r;
    endfunction

    // Advances the shadow detector by one beat and returns its outcome.
    function automatic res_t chord_next(item_t it);
        res_t        r;
        bit          rctrl;
        bit          others;
        bit          swallow;
        bit          settled;
        bit          via_idle;
        int          slot;
        int          i;
        logic [7:0]  k;
        logic [48:0] now49;
        logic [48:0] win_us;
        r       = '0;
        swallow = 1'b0;
        now49   = {1'b0, it.now_us};

        // Polls only apply the time-outs.
        if (it.action == ACT_POLL)
        begin
            if (det_mode == MODE_CMD && now49 > cmd_deadline_us)
                r = leave_cmd(r);
            else if (det_mode == MODE_ARMED && now49 > arm_deadline_us)
                det_mode = MODE_IDLE;
            r.mode_now = det_mode;
            return r;
        end

        rctrl  = it.modifiers[RCTRL_BIT];
        others = ((it.modifiers & ~RCTRL_MASK) != 8'h00) || (it.keys != '0);

        if (det_mode == MODE_CMD)
        begin
            // The first fresh Esc or digit in field order decides.
            swallow = 1'b1;
            settled = 1'b0;
            for (i = 0; i < NUM_KEY_FIELDS; i++)
            begin
                k = it.keys[i];
                if (!settled && k != KC_NONE && !held_last_report(k))
                begin
                    if (k == KC_ESC)
                    begin
                        r       = leave_cmd(r);
                        settled = 1'b1;
                    end
                    else
                    begin
                        slot = slot_of_key(k);
                        if (slot >= 0)
                        begin
                            if (slot_mask_q[slot])
                            begin
                                r.do_switch  = 1'b1;
                                r.event_code = EV_SWITCHED;
                            end
                            else
                                r.event_code = EV_INVALID;
                            r.event_slot = 4'(slot);
                            r            = leave_cmd(r);
                            settled      = 1'b1;
                        end
                    end
                end
            end
            if (det_mode == MODE_CMD && now49 > cmd_deadline_us)
                r = leave_cmd(r);
        end
        else
        begin
            via_idle = 1'b1;
            if (det_mode == MODE_ARMED)
            begin
                if (now49 > arm_deadline_us)
                    det_mode = MODE_IDLE;
                else if (rctrl && !others && !rctrl_prev)
                begin
                    det_mode        = MODE_CMD;
                    cmd_deadline_us = now49 + 49'(cmd_ms_q) * 49'd1000;
                    r.event_code    = EV_CMD_ON;
                    swallow         = 1'b1;
                    via_idle        = 1'b0;
                end
                else if (others)
                    det_mode = MODE_IDLE;
                else
                    via_idle = 1'b0;
            end

            // Lone tap tracking while idle.
            if (via_idle)
            begin
                if (rctrl && !others && !rctrl_prev)
                begin
                    tap_open      = 1'b1;
                    tap_origin_us = it.now_us;
                end
                else if (tap_open && !rctrl)
                begin
                    win_us = 49'(tap_ms_q) * 49'd1000;
                    if (!others && (it.now_us < tap_origin_us ||
                        ({1'b0, it.now_us} - {1'b0, tap_origin_us}) < win_us))
                    begin
                        det_mode        = MODE_ARMED;
                        arm_deadline_us = now49 + win_us;
                    end
                    tap_open = 1'b0;
                end
                else if (others)
                    tap_open = 1'b0;
            end
        end

        rctrl_prev = rctrl;
        for (i = 0; i < NUM_KEY_FIELDS; i++)
            keys_prev[i] = it.keys[i];
        r.forward_report = !swallow;
        r.mode_now       = det_mode;
        return r;
    endfunction

    // Builds one beat; key0 is the low byte of keys.
    function automatic item_t mk_beat(logic act, logic [47:0] t, logic [7:0] mods,
                                      logic [47:0] keys);
        item_t b;
        b.action    = act;
        b.now_us    = t;
        b.modifiers = mods;
        b.keys      = keys;
        return b;
    endfunction

    function automatic res_t outcome(bit fwd, bit empty, bit sw, logic [1:0] code,
                                     logic [3:0] slot, bit off, logic [1:0] md);
        res_t r;
        r.forward_report    = fwd;
        r.send_empty_report = empty;
        r.do_switch         = sw;
        r.event_code        = code;
        r.event_slot        = slot;
        r.command_off       = off;
        r.mode_now          = md;
        return r;
    endfunction

    function automatic void probe(item_t b);
        probe_t p;
        p.beat   = b;
        p.pinned = 1'b0;
        p.want   = '0;
        probes.push_back(p);
    endfunction

    function automatic void probe_pinned(item_t b, res_t want);
        probe_t p;
        p.beat   = b;
        p.pinned = 1'b1;
        p.want   = want;
        probes.push_back(p);
    endfunction

    // Letters and high keycodes: never Esc nor a digit.
    function automatic logic [7:0] plain_key();
        if ($urandom_range(0, 1) == 0)
            return 8'($urandom_range(8'h04, 8'h1D));
        return 8'($urandom_range(8'h63, 8'hFF));
    endfunction

    function automatic logic [7:0] digit_key(int slot);
        if (slot == 0)
            return ($urandom_range(0, 1) == 0) ? KC_0 : KC_KP_0;
        return ($urandom_range(0, 1) == 0) ? KC_1 + 8'(slot - 1) : KC_KP_1 + 8'(slot - 1);
    endfunction

    // Places one key at a random position, sometimes among other keys.
    function automatic logic [47:0] keys_with(logic [7:0] k);
        logic [NUM_KEY_FIELDS-1:0][7:0] ks;
        int pos;
        int i;
        ks  = '0;
        pos = $urandom_range(0, NUM_KEY_FIELDS - 1);
        for (i = 0; i < NUM_KEY_FIELDS; i++)
            if (i != pos && $urandom_range(0, 3) == 0)
                ks[i] = (i < pos) ? plain_key() : 8'($urandom);
        ks[pos] = k;
        return ks;
    endfunction

    // Gap that keeps a tap or the armed window open, mostly short.
    function automatic int unsigned inside_gap(int unsigned win);
        if (win == 0)
            return $urandom_range(0, 20);
        if ($urandom_range(0, 1) == 0)
            return $urandom_range(0, (win > 5000) ? 4999 : win - 1);
        return $urandom_range(0, win - 1);
    endfunction

    // Queues one random sequence: mostly full chords, the rest noise.
    task automatic plan_sequence();
        int unsigned win;
        int unsigned cmd_win;
        int          pick;
        int          flaw;
        logic [47:0] t_cmd;
        logic [7:0]  extra;
        win     = int'(tap_ms_q) * 1000;
        cmd_win = int'(cmd_ms_q) * 1000;
        pick    = $urandom_range(0, 99);
        if (pick < 70)
        begin
            // Release, tap, second press, then something in command mode.
            flaw = $urandom_range(0, 9);
            clock_us += inside_gap(win);
            key_beats.push_back(mk_beat(ACT_REPORT, clock_us, 8'h00, '0));
            clock_us += inside_gap(win);
            key_beats.push_back(mk_beat(ACT_REPORT, clock_us, RCTRL_MASK, '0));
            if (flaw == 0)
                clock_us += win + $urandom_range(0, 1000);
            else if (flaw == 1)
                clock_us -= $urandom_range(1, 500);
            else
                clock_us += inside_gap(win);
            key_beats.push_back(mk_beat(ACT_REPORT, clock_us, 8'h00, '0));
            clock_us += inside_gap(win);
            if (flaw == 2)
            begin
                extra = 8'($urandom) & ~RCTRL_MASK;
                if (extra == 8'h00)
                    extra = 8'h01;
                key_beats.push_back(mk_beat(ACT_REPORT, clock_us, RCTRL_MASK | extra, '0));
            end
            else
                key_beats.push_back(mk_beat(ACT_REPORT, clock_us, RCTRL_MASK, '0));
            t_cmd = clock_us;
            repeat ($urandom_range(0, 2))
            begin
                clock_us += $urandom_range(0, 2000);
                key_beats.push_back(mk_beat(ACT_REPORT, clock_us, 8'($urandom),
                                            keys_with(plain_key())));
            end
            pick = $urandom_range(0, 99);
            clock_us += $urandom_range(0, 2000);
            if (pick < 45)
                key_beats.push_back(mk_beat(ACT_REPORT, clock_us, 8'($urandom),
                                            keys_with(digit_key($urandom_range(0, 9)))));
            else if (pick < 65)
                key_beats.push_back(mk_beat(ACT_REPORT, clock_us, 8'($urandom),
                                            keys_with(KC_ESC)));
            else if (pick < 80)
            begin
                clock_us = t_cmd + cmd_win + $urandom_range(0, 2);
                key_beats.push_back(mk_beat(ACT_POLL, clock_us, 8'($urandom),
                                            48'({$urandom, $urandom})));
            end
            else if (pick < 90)
            begin
                clock_us = t_cmd + cmd_win + $urandom_range(0, 2);
                key_beats.push_back(mk_beat(ACT_REPORT, clock_us, RCTRL_MASK, '0));
            end
        end
        else if (pick < 85)
        begin
            clock_us += $urandom_range(0, 2 * win + 10);
            key_beats.push_back(mk_beat(ACT_REPORT, clock_us, 8'($urandom),
                                        48'({$urandom, $urandom})));
        end
        else if (pick < 95)
        begin
            clock_us += $urandom_range(0, 2 * win + 10);
            key_beats.push_back(mk_beat(ACT_POLL, clock_us, 8'($urandom),
                                        48'({$urandom, $urandom})));
        end
        else
        begin
            // Jump anywhere, backwards included.
            clock_us = 48'({$urandom, $urandom});
            key_beats.push_back(mk_beat(ACT_REPORT, clock_us, 8'($urandom),
                                        48'({$urandom, $urandom})));
        end
    endtask

    // Offers one beat after a random gap and records its expected outcome.
    task automatic send_beat(item_t b, bit pinned, res_t want);
        int   gap;
        res_t predicted;
        if ($urandom_range(0, 39) == 0)
            tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        action    <= b.action;
        now_us    <= b.now_us;
        modifiers <= b.modifiers;
        key0      <= b.keys[0];
        key1      <= b.keys[1];
        key2      <= b.keys[2];
        key3      <= b.keys[3];
        key4      <= b.keys[4];
        key5      <= b.keys[5];
        do @(posedge clk); while (in_stall);

        predicted = chord_next(b);
        pending_outcomes.push_back(pinned ? want : predicted);
        beats_sent++;
        case (predicted.event_code)
            EV_CMD_ON:   n_cmd_on++;
            EV_SWITCHED: n_switched++;
            EV_INVALID:  n_invalid++;
            default:     if (predicted.command_off) n_other_exit++;
        endcase
    endtask

    // Writes all three registers back to back while the block is idle.
    task automatic load_config(logic [15:0] tap, logic [15:0] cmd, logic [15:0] mask);
        logic [7:0]  idx [3];
        logic [15:0] val [3];
        int          i;
        idx = '{CFG_TAP_WINDOW, CFG_CMD_TIMEOUT, CFG_SLOT_MASK};
        val = '{tap, cmd, mask};
        for (i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do @(posedge clk); while (!cfg_ready);
            case (idx[i])
                CFG_TAP_WINDOW:  tap_ms_q    = val[i][13:0];
                CFG_CMD_TIMEOUT: cmd_ms_q    = val[i];
                CFG_SLOT_MASK:   slot_mask_q = val[i][9:0];
                default:         ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // Waits for every outstanding result, then lets the pipeline go quiet.
    task automatic settle();
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Result side: random stalls, one long hold-off, field-by-field compare.
    initial
    begin : result_side
        int   stall_len;
        res_t want;
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                rx_burst = !rx_burst;
            if (results_seen == HOLD_AT_RESULT)
                stall_len = HOLD_CYCLES;
            else
                stall_len = rx_burst ? 0 : $urandom_range(0, 7);
            if (stall_len > 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_len) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);

            results_seen++;
            if (pending_outcomes.size() == 0)
            begin
                $error("result beat arrived with no expectation pending");
                mismatches++;
            end
            else
            begin
                want = pending_outcomes.pop_front();
                check_field("forward_report", want.forward_report, forward_report);
                check_field("send_empty_report", want.send_empty_report, send_empty_report);
                check_field("do_switch", want.do_switch, do_switch);
                check_field("event_code", want.event_code, event_code);
                check_field("event_slot", want.event_slot, event_slot);
                check_field("command_off", want.command_off, command_off);
                check_field("mode_now", want.mode_now, mode_now);
            end
        end
    end

    // Guards against a hung handshake.
    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Main sequence: reset, directed beats, then random settings.
    initial
    begin : stimulus
        logic [15:0] tap_set  [NUM_SETTINGS];
        logic [15:0] cmd_set  [NUM_SETTINGS];
        logic [15:0] mask_set [NUM_SETTINGS];
        int          ph;
        int          sent;
        int          directed;
        tap_set  = '{16'd300, 16'd1, 16'd10000, 16'hFFFF, 16'd0, 16'd0};
        cmd_set  = '{16'd3000, 16'd1, 16'd60000, 16'hFFFF, 16'd0, 16'd0};
        mask_set = '{16'h03FF, 16'h0155, 16'h02AA, 16'hFFFF, 16'h0000, 16'h0000};
        mask_set[4] = 16'($urandom);
        tap_set[5]  = 16'($urandom_range(1, 10000));
        cmd_set[5]  = 16'($urandom_range(1, 60000));
        mask_set[5] = 16'($urandom_range(0, 1023));

        reset_shadow();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats at the reset windows: 300 ms tap, 3000 ms command, no slots.
        probe_pinned(mk_beat(ACT_POLL, 48'd0, 8'h00, '0),
                     outcome(0, 0, 0, EV_NONE, 0, 0, MODE_IDLE));
        probe_pinned(mk_beat(ACT_REPORT, 48'd1000, 8'hFF, 48'hFFFF_FFFF_FFFF),
                     outcome(1, 0, 0, EV_NONE, 0, 0, MODE_IDLE));
        probe_pinned(mk_beat(ACT_REPORT, 48'd2000, 8'h00, '0),
                     outcome(1, 0, 0, EV_NONE, 0, 0, MODE_IDLE));
        probe_pinned(mk_beat(ACT_REPORT, 48'd3000, RCTRL_MASK, '0),
                     outcome(1, 0, 0, EV_NONE, 0, 0, MODE_IDLE));
        probe_pinned(mk_beat(ACT_REPORT, 48'd50000, 8'h00, '0),
                     outcome(1, 0, 0, EV_NONE, 0, 0, MODE_ARMED));
        probe_pinned(mk_beat(ACT_REPORT, 48'd60000, RCTRL_MASK, '0),
                     outcome(0, 0, 0, EV_CMD_ON, 0, 0, MODE_CMD));
        // A plain letter is skipped; the top-row 1 is unpaired.
        probe_pinned(mk_beat(ACT_REPORT, 48'd70000, 8'h00, {16'h0, 8'h00, 8'h00, KC_1, 8'h04}),
                     outcome(0, 1, 0, EV_INVALID, 4'd1, 1, MODE_IDLE));
        probe(mk_beat(ACT_REPORT, 48'd80000, RCTRL_MASK, '0));
        probe(mk_beat(ACT_REPORT, 48'd90000, 8'h00, '0));
        probe(mk_beat(ACT_REPORT, 48'd100000, RCTRL_MASK, '0));
        // Esc in the last field cancels.
        probe_pinned(mk_beat(ACT_REPORT, 48'd110000, 8'h00, {KC_ESC, 32'h0, 8'h04}),
                     outcome(0, 1, 0, EV_NONE, 0, 1, MODE_IDLE));
        probe(mk_beat(ACT_REPORT, 48'd120000, RCTRL_MASK, '0));
        probe(mk_beat(ACT_REPORT, 48'd130000, 8'h00, '0));
        probe(mk_beat(ACT_REPORT, 48'd140000, RCTRL_MASK, '0));
        // Command time-out: not at the deadline, only one past it.
        probe(mk_beat(ACT_POLL, 48'd3140000, 8'h00, '0));
        probe_pinned(mk_beat(ACT_POLL, 48'd3140001, 8'h00, '0),
                     outcome(0, 1, 0, EV_NONE, 0, 1, MODE_IDLE));
        probe(mk_beat(ACT_REPORT, 48'd3900000, 8'h00, '0));
        probe(mk_beat(ACT_REPORT, 48'd4000000, RCTRL_MASK, '0));
        probe(mk_beat(ACT_REPORT, 48'd4299999, 8'h00, '0));
        // Armed window expiring on a poll.
        probe_pinned(mk_beat(ACT_POLL, 48'd4600000, 8'h00, '0),
                     outcome(0, 0, 0, EV_NONE, 0, 0, MODE_IDLE));
        // A tap of exactly the window does not arm.
        probe(mk_beat(ACT_REPORT, 48'd5000000, RCTRL_MASK, '0));
        probe(mk_beat(ACT_REPORT, 48'd5300000, 8'h00, '0));
        // Time running backwards counts as inside the window.
        probe(mk_beat(ACT_REPORT, 48'd6000000, RCTRL_MASK, '0));
        probe(mk_beat(ACT_REPORT, 48'd5999000, 8'h00, '0));
        // Chord at the top of the time range; deadlines go past 48 bits.
        probe(mk_beat(ACT_REPORT, MAX_US - 48'd5, RCTRL_MASK, '0));
        probe(mk_beat(ACT_REPORT, MAX_US - 48'd4, 8'h00, '0));
        probe(mk_beat(ACT_REPORT, MAX_US - 48'd3, RCTRL_MASK, '0));
        probe(mk_beat(ACT_POLL, MAX_US, 8'h00, '0));
        probe_pinned(mk_beat(ACT_REPORT, MAX_US, 8'h00, {40'h0, KC_KP_9}),
                     outcome(0, 1, 0, EV_INVALID, 4'd9, 1, MODE_IDLE));

        foreach (probes[i])
            send_beat(probes[i].beat, probes[i].pinned, probes[i].want);
        in_valid <= 1'b0;
        directed = probes.size();

        // Random sequences under each register setting.
        for (ph = 0; ph < NUM_SETTINGS; ph++)
        begin
            settle();
            load_config(tap_set[ph], cmd_set[ph], mask_set[ph]);
            clock_us = 48'({$urandom, $urandom});
            key_beats.delete();
            sent = 0;
            while (sent < BEATS_PER_SETTING)
            begin
                if (key_beats.size() == 0)
                    plan_sequence();
                send_beat(key_beats.pop_front(), 1'b0, '0);
                sent++;
            end
            in_valid <= 1'b0;
        end

        settle();
        repeat (8) @(posedge clk);
        $display("Run covered %0d beats (%0d directed) under %0d register settings.",
                 beats_sent, directed, NUM_SETTINGS + 1);
        $display("Predicted %0d command entries, %0d switches, %0d invalid slots, %0d other exits.",
                 n_cmd_on, n_switched, n_invalid, n_other_exit);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/kbhcd_pkg.sv
hw/rtl/kbhcd_cfg.sv
hw/rtl/kbhcd_keyscan.sv
hw/rtl/kbhcd_core.sv
hw/rtl/keyboard_hotkey_chord_detector.sv
tb/tb_top.sv
